FILE: design/merge_sort_with_comparison_count_macros.svh
// assertion macros for the merge sort block
`ifndef MERGE_SORT_WITH_COMPARISON_COUNT_MACROS_SVH
`define MERGE_SORT_WITH_COMPARISON_COUNT_MACROS_SVH
`ifndef SYNTHESIS
`define MSCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("merge sort check failed");
`define MSCC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("merge sort check failed");
`define MSCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("merge sort check failed");
`else
`define MSCC_ASSERT(label, clk, rst, prop)
`define MSCC_ASSERT_IMP(label, clk, rst, ante, cons)
`define MSCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/mscc_pkg.sv
// shared types and constants of the merge sort block
package mscc_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 9;
   localparam int CMPCNT_W = 13;
   localparam int COUNT_OUT_W = 10;
   localparam logic [CMPCNT_W-1:0] CMP_MAX = 13'd8191;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_SORT = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] PH_LEFT = 2'd0;
   localparam logic [1:0] PH_RIGHT = 2'd1;
   localparam logic [1:0] PH_MERGE = 2'd2;

   typedef struct packed {
      logic append;
      logic clear;
      logic read;
      logic sort_start;
      logic push_left;
      logic push_right;
      logic pop;
      logic merge_init;
      logic merge_wr;
      logic copy_wr;
      logic rsp_load;
      logic rsp_read;
   } cmd_type;

   typedef struct packed {
      logic stack_empty;
      logic trivial;
      logic [1:0] phase;
      logic merge_last;
      logic copy_last;
      logic count_gt1;
      logic full;
   } stat_type;

endpackage

FILE: design/mscc_dp.sv
// datapath: element and scratch memories, frame stack, merge indices, response registers
module mscc_dp #(
   parameter int MAX_ITEMS = 512
) (
   input  logic clock,
   input  logic reset,
   input  mscc_pkg::cmd_type cmd,
   output mscc_pkg::stat_type stat,
   input  logic signed [mscc_pkg::VALUE_W-1:0] req_value,
   input  logic [mscc_pkg::INDEX_W-1:0] req_index,
   output logic signed [mscc_pkg::VALUE_W-1:0] rsp_data,
   output logic [mscc_pkg::CMPCNT_W-1:0] rsp_comparisons,
   output logic [mscc_pkg::COUNT_OUT_W-1:0] rsp_element_count,
   output logic rsp_status
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int DEPTH = IDX_W + 1;
   localparam int TI_W = $clog2(DEPTH);
   localparam int SP_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > mscc_pkg::INDEX_W) ? CNT_W : mscc_pkg::INDEX_W;

   logic signed [mscc_pkg::VALUE_W-1:0] elem_mem [MAX_ITEMS];
   logic signed [mscc_pkg::VALUE_W-1:0] scr_mem [MAX_ITEMS];
   logic signed [mscc_pkg::VALUE_W-1:0] rd0_ff, rd1_ff, srd_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [mscc_pkg::CMPCNT_W-1:0] cmp_ff, cmp_in;

   logic [IDX_W-1:0] lo_stk_ff [DEPTH];
   logic [IDX_W-1:0] hi_stk_ff [DEPTH];
   logic [1:0] ph_stk_ff [DEPTH];
   logic [SP_W-1:0] sp_ff, sp_dec;
   logic [TI_W-1:0] top_idx, push_idx;
   logic [IDX_W-1:0] top_lo, top_hi, mid;
   logic [1:0] top_ph;

   logic [CNT_W-1:0] a_ff, b_ff;
   logic [IDX_W-1:0] k_ff, t_ff;
   logic a_live, b_live, both, take_a;
   logic idx_ok_ff;
   logic [CMP_W-1:0] index_ext, count_ext;
   logic [IDX_W-1:0] rd0_addr;
   logic full;

   assign full = (count_ff == CNT_W'(MAX_ITEMS));
   assign sp_dec = sp_ff - SP_W'(1);
   assign top_idx = sp_dec[TI_W-1:0];
   assign push_idx = sp_ff[TI_W-1:0];
   assign top_lo = lo_stk_ff[top_idx];
   assign top_hi = hi_stk_ff[top_idx];
   assign top_ph = ph_stk_ff[top_idx];
   assign mid = top_lo + ((top_hi - top_lo) >> 1);

   assign a_live = (a_ff <= CNT_W'(mid));
   assign b_live = (b_ff <= CNT_W'(top_hi));
   assign both = a_live && b_live;
   // ties go to the left run
   assign take_a = both ? (rd0_ff <= rd1_ff) : a_live;

   assign index_ext = CMP_W'(req_index);
   assign count_ext = CMP_W'(count_ff);
   assign rd0_addr = cmd.read ? index_ext[IDX_W-1:0] : a_ff[IDX_W-1:0];

   assign stat.stack_empty = (sp_ff == '0);
   assign stat.trivial = (top_lo >= top_hi);
   assign stat.phase = top_ph;
   assign stat.merge_last = (k_ff == top_hi);
   assign stat.copy_last = (t_ff == top_hi);
   assign stat.count_gt1 = (count_ff > CNT_W'(1));
   assign stat.full = full;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      cmp_in = cmp_ff;
      if (cmd.sort_start) begin
         cmp_in = '0;
      end else if (cmd.merge_wr && both && (cmp_ff != mscc_pkg::CMP_MAX)) begin
         cmp_in = cmp_ff + mscc_pkg::CMPCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cmp_ff <= '0;
         sp_ff <= '0;
      end else begin
         count_ff <= count_in;
         cmp_ff <= cmp_in;
         if (cmd.sort_start) begin
            sp_ff <= stat.count_gt1 ? SP_W'(1) : '0;
         end else if (cmd.push_left || cmd.push_right) begin
            sp_ff <= sp_ff + SP_W'(1);
         end else if (cmd.pop) begin
            sp_ff <= sp_dec;
         end
      end
   end

   // frame stack of the recursion
   always_ff @(posedge clock) begin
      if (cmd.sort_start) begin
         lo_stk_ff[0] <= '0;
         hi_stk_ff[0] <= IDX_W'(count_ff - CNT_W'(1));
         ph_stk_ff[0] <= mscc_pkg::PH_LEFT;
      end else if (cmd.push_left) begin
         ph_stk_ff[top_idx] <= mscc_pkg::PH_RIGHT;
         lo_stk_ff[push_idx] <= top_lo;
         hi_stk_ff[push_idx] <= mid;
         ph_stk_ff[push_idx] <= mscc_pkg::PH_LEFT;
      end else if (cmd.push_right) begin
         ph_stk_ff[top_idx] <= mscc_pkg::PH_MERGE;
         lo_stk_ff[push_idx] <= mid + IDX_W'(1);
         hi_stk_ff[push_idx] <= top_hi;
         ph_stk_ff[push_idx] <= mscc_pkg::PH_LEFT;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.merge_init) begin
         a_ff <= CNT_W'(top_lo);
         b_ff <= CNT_W'(mid) + CNT_W'(1);
         k_ff <= top_lo;
      end else if (cmd.merge_wr) begin
         k_ff <= k_ff + IDX_W'(1);
         if (take_a) begin
            a_ff <= a_ff + CNT_W'(1);
         end else begin
            b_ff <= b_ff + CNT_W'(1);
         end
      end
      if (cmd.merge_wr && stat.merge_last) begin
         t_ff <= top_lo;
      end else if (cmd.copy_wr) begin
         t_ff <= t_ff + IDX_W'(1);
      end
      if (cmd.read) begin
         idx_ok_ff <= (index_ext < count_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !full) begin
         elem_mem[count_ff[IDX_W-1:0]] <= req_value;
      end else if (cmd.copy_wr) begin
         elem_mem[t_ff] <= srd_ff;
      end
      rd0_ff <= elem_mem[rd0_addr];
      rd1_ff <= elem_mem[b_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.merge_wr) begin
         scr_mem[k_ff] <= take_a ? rd0_ff : rd1_ff;
      end
      srd_ff <= scr_mem[t_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data <= (cmd.rsp_read && idx_ok_ff) ? rd0_ff : '0;
         rsp_comparisons <= cmp_in;
         rsp_element_count <= mscc_pkg::COUNT_OUT_W'(count_in);
         rsp_status <= cmd.rsp_read ? !idx_ok_ff : (cmd.append && full);
      end
   end

endmodule

FILE: design/mscc_ctrl.sv
// controller: request handshake, recursion sequencer, response valid
module mscc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  mscc_pkg::stat_type stat,
   output mscc_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD_WAIT = 3'd1;
   localparam logic [2:0] ST_FRAME = 3'd2;
   localparam logic [2:0] ST_MERGE_RD = 3'd3;
   localparam logic [2:0] ST_MERGE_WR = 3'd4;
   localparam logic [2:0] ST_COPY_RD = 3'd5;
   localparam logic [2:0] ST_COPY_WR = 3'd6;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free, accept;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && slot_free);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  mscc_pkg::OP_APPEND: begin
                     cmd.append = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  mscc_pkg::OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  mscc_pkg::OP_READ: begin
                     cmd.read = 1'b1;
                     state_in = ST_RD_WAIT;
                  end
                  default: begin
                     cmd.sort_start = 1'b1;
                     if (stat.count_gt1) begin
                        state_in = ST_FRAME;
                     end else begin
                        cmd.rsp_load = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_read = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FRAME: begin
            priority if (stat.stack_empty) begin
               if (slot_free) begin
                  cmd.rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (stat.trivial) begin
               cmd.pop = 1'b1;
            end else if (stat.phase == mscc_pkg::PH_LEFT) begin
               cmd.push_left = 1'b1;
            end else if (stat.phase == mscc_pkg::PH_RIGHT) begin
               cmd.push_right = 1'b1;
            end else begin
               cmd.merge_init = 1'b1;
               state_in = ST_MERGE_RD;
            end
         end
         ST_MERGE_RD: begin
            state_in = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            cmd.merge_wr = 1'b1;
            state_in = stat.merge_last ? ST_COPY_RD : ST_MERGE_RD;
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            if (stat.copy_last) begin
               cmd.pop = 1'b1;
               state_in = ST_FRAME;
            end else begin
               state_in = ST_COPY_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/merge_sort_with_comparison_count.sv
// Merge sort engine with comparison count over a list of signed 32-bit values.
// Request channel (req_valid/req_stall): req_op selects append of req_value,
// sort, read of the element at req_index, or clear. Response channel
// (rsp_valid/rsp_stall) returns one response per request: read data, the
// comparison count of the last sort, the element count and a status bit.
// Append and clear respond in the cycle after acceptance, a read after its
// read-wait state. A sort walks the split tree with a frame stack and one
// shared merge unit: each merge step and each copy-back step passes a read
// state and a write state (registered memory reads), a trivial frame is
// popped, and any other frame is visited to push its left half, push its
// right half and start its merge; requests stall meanwhile. Appends and clears
// can be taken back to back while responses are taken; a read holds off the next.
// Reset clears the element count, the comparison count and the stack; the
// stores hold nothing until written. When the receiver stalls, the held
// response stays, and one more request may be accepted only as it is taken.
module merge_sort_with_comparison_count #(
   parameter int MAX_ITEMS = 512
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   input  logic signed [31:0] req_value,
   input  logic [8:0] req_index,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_data,
   output logic [12:0] rsp_comparisons,
   output logic [9:0] rsp_element_count,
   output logic rsp_status
);

   `include "merge_sort_with_comparison_count_macros.svh"

   mscc_pkg::cmd_type cmd;
   mscc_pkg::stat_type stat;

   mscc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat(stat),
      .cmd(cmd)
   );

   mscc_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_value(req_value),
      .req_index(req_index),
      .rsp_data(rsp_data),
      .rsp_comparisons(rsp_comparisons),
      .rsp_element_count(rsp_element_count),
      .rsp_status(rsp_status)
   );

   `MSCC_ASSERT(a_one_op, clock, reset, $onehot0({cmd.append, cmd.clear, cmd.read, cmd.sort_start}))
   `MSCC_ASSERT_IMP(a_merge_frame, clock, reset, cmd.merge_wr || cmd.copy_wr, !stat.stack_empty)
   `MSCC_ASSERT_NEXT(a_sort_busy, clock, reset, cmd.sort_start && stat.count_gt1, req_stall)

endmodule

FILE: dv/merge_sort_with_comparison_count_tb.sv
// testbench for the merge sort block: table of directed requests, random traffic, predictor check
module merge_sort_with_comparison_count_tb;

   localparam int DEPTH = 512;

   typedef struct packed {
      logic signed [31:0] data;
      logic [12:0] comparisons;
      logic [9:0] element_count;
      logic status;
   } resp_type;

   typedef struct {
      logic [1:0] op;
      logic signed [31:0] value;
      logic [8:0] index;
      bit known;
      resp_type want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_op = mscc_pkg::OP_CLEAR;
   logic signed [31:0] req_value = 0;
   logic [8:0] req_index = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_data;
   logic [12:0] rsp_comparisons;
   logic [9:0] rsp_element_count;
   logic rsp_status;

   merge_sort_with_comparison_count uut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // predictor state
   logic signed [31:0] list_model [DEPTH];
   logic signed [31:0] merge_buf [DEPTH];
   int list_len = 0;
   logic [12:0] last_cmp = 0;
   resp_type pending_resp [$];
   int errors = 0;
   bit quiet_tail = 0;
   int hold_cycles = 0;
   int stall_left = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   function automatic void bump_cmp();
      if (last_cmp != mscc_pkg::CMP_MAX) last_cmp++;
   endfunction

   function automatic void merge_halves(int lo, int mid, int hi);
      int a, b, k;
      a = lo; b = mid + 1; k = lo;
      while (a <= mid && b <= hi) begin
         bump_cmp();
         if (list_model[a] <= list_model[b]) merge_buf[k++] = list_model[a++];
         else merge_buf[k++] = list_model[b++];
      end
      while (a <= mid) merge_buf[k++] = list_model[a++];
      while (b <= hi) merge_buf[k++] = list_model[b++];
      for (int t = lo; t <= hi; t++) list_model[t] = merge_buf[t];
   endfunction

   function automatic void sort_span(int lo, int hi);
      int mid;
      if (lo >= hi) return;
      mid = lo + (hi - lo) / 2;
      sort_span(lo, mid);
      sort_span(mid + 1, hi);
      merge_halves(lo, mid, hi);
   endfunction

   function automatic resp_type predict_list_op(logic [1:0] op, logic signed [31:0] value,
                                               logic [8:0] index);
      resp_type r;
      r.data = 0;
      r.status = 0;
      case (op)
         mscc_pkg::OP_APPEND: begin
            if (list_len >= DEPTH) r.status = 1;
            else list_model[list_len++] = value;
         end
         mscc_pkg::OP_SORT: begin
            last_cmp = 0;
            if (list_len > 1) sort_span(0, list_len - 1);
         end
         mscc_pkg::OP_READ: begin
            if (index < list_len) r.data = list_model[index];
            else r.status = 1;
         end
         default: list_len = 0;
      endcase
      r.comparisons = last_cmp;
      r.element_count = 10'(list_len);
      return r;
   endfunction

   // drive one request and wait for acceptance
   task automatic send(input logic [1:0] op, input logic signed [31:0] value,
                       input logic [8:0] index, input bit known, input resp_type want);
      resp_type p;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (req_stall);
      p = predict_list_op(op, value, index);
      if (known && p != want) begin
         report("directed table", 0, 1);
      end
      pending_resp.push_back(p);
   endtask

   task automatic idle_until_drained();
      req_valid <= 0;
      while (pending_resp.size() != 0) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      resp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_resp.size() == 0) begin
            report("unexpected response", 0, 0);
         end else begin
            w = pending_resp.pop_front();
            if (rsp_data !== w.data) report("data", rsp_data, w.data);
            if (rsp_comparisons !== w.comparisons)
               report("comparisons", 32'(rsp_comparisons), 32'(w.comparisons));
            if (rsp_element_count !== w.element_count)
               report("element_count", 32'(rsp_element_count), 32'(w.element_count));
            if (rsp_status !== w.status) report("status", 32'(rsp_status), 32'(w.status));
         end
      end
   end

   // receiver stalls in random bursts; a long hold-off when requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else if (quiet_tail) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 0;
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(0, 7)) - 32'sd4);
         default: return $signed($urandom());
      endcase
   endfunction

   initial begin
      row_type rows [$];
      row_type r;
      resp_type z;
      int n;
      z = '{0, 0, 0, 0};
      // directed table: reads on empty, extremes, ties, single-element sort, clear
      rows.push_back('{mscc_pkg::OP_READ, 0, 9'd0, 1, '{0, 0, 0, 1}});
      rows.push_back('{mscc_pkg::OP_SORT, 0, 0, 1, '{0, 0, 0, 0}});
      rows.push_back('{mscc_pkg::OP_APPEND, 32'sh7fff_ffff, 0, 1, '{0, 0, 1, 0}});
      rows.push_back('{mscc_pkg::OP_SORT, 0, 0, 1, '{0, 0, 1, 0}});
      rows.push_back('{mscc_pkg::OP_APPEND, 32'sh8000_0000, 0, 1, '{0, 0, 2, 0}});
      rows.push_back('{mscc_pkg::OP_APPEND, -32'sd1, 0, 0, z});
      rows.push_back('{mscc_pkg::OP_APPEND, 32'sd0, 0, 0, z});
      rows.push_back('{mscc_pkg::OP_APPEND, -32'sd1, 0, 0, z});
      rows.push_back('{mscc_pkg::OP_APPEND, 32'sd5, 0, 0, z});
      rows.push_back('{mscc_pkg::OP_SORT, 0, 0, 0, z});
      for (int i = 0; i < 6; i++) rows.push_back('{mscc_pkg::OP_READ, 0, 9'(i), 0, z});
      rows.push_back('{mscc_pkg::OP_READ, 0, 9'd511, 0, z});
      rows.push_back('{mscc_pkg::OP_CLEAR, 32'shffff_ffff, 9'h1ff, 0, z});
      rows.push_back('{mscc_pkg::OP_READ, 0, 9'd0, 0, z});
      rows.push_back('{mscc_pkg::OP_SORT, 0, 0, 1, '{0, 0, 0, 0}});
      repeat (8) @(posedge clock);
      reset <= 0;
      foreach (rows[i]) send(rows[i].op, rows[i].value, rows[i].index, rows[i].known,
                             rows[i].want);
      idle_until_drained();
      // fill the store to the top, overflow it, sort the full list, read back
      for (int i = 0; i < DEPTH + 2; i++) send(mscc_pkg::OP_APPEND, pick_value(), 0, 0, z);
      send(mscc_pkg::OP_READ, 0, 9'd511, 0, z);
      send(mscc_pkg::OP_SORT, 0, 0, 0, z);
      for (int i = 0; i < 20; i++)
         send(mscc_pkg::OP_READ, 0, 9'($urandom_range(0, 511)), 0, z);
      send(mscc_pkg::OP_CLEAR, 0, 0, 0, z);
      idle_until_drained();
      // long receiver hold-off while requests keep coming
      hold_cycles = 300;
      for (int i = 0; i < 12; i++) send(mscc_pkg::OP_APPEND, pick_value(), 0, 0, z);
      idle_until_drained();
      // random lists: mostly small, load, sort, read back, with noise
      n = 0;
      while (n < 1300) begin
         int len;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 16);
         send(mscc_pkg::OP_CLEAR, $signed($urandom()), 9'($urandom()), 0, z);
         for (int i = 0; i < len; i++)
            send(mscc_pkg::OP_APPEND, pick_value(), 9'($urandom()), 0, z);
         if ($urandom_range(0, 7) != 0)
            send(mscc_pkg::OP_SORT, $signed($urandom()), 9'($urandom()), 0, z);
         for (int i = 0; i < len / 2 + 2; i++) begin
            if ($urandom_range(0, 9) == 0)
               send(2'($urandom()), pick_value(), 9'($urandom()), 0, z);
            else send(mscc_pkg::OP_READ, 0, 9'($urandom_range(0, len + 1)), 0, z);
         end
         n += len + len / 2 + 4;
         if (n > 1100) quiet_tail = 1;
      end
      idle_until_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("merge_sort_with_comparison_count_tb: done, clean");
      else $display("merge_sort_with_comparison_count_tb: done, errors");
      $finish;
   end

   initial begin
      #40000000;
      $display("merge_sort_with_comparison_count_tb: done, errors");
      $finish;
   end
endmodule
